// File: hdl/hpt_pkg.sv
// Shared types, constants and helpers for the homogeneous point transform.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hpt_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int COEF_W   = 32;
    localparam int IDX_W    = 3;

    // Identity matrix, 1.0 on the diagonal in Q16.16.
    localparam logic [REG_W-1:0] MAT_R0_C01_RST = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] MAT_R0_C23_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] MAT_R1_C01_RST = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] MAT_R1_C23_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] MAT_R2_C01_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] MAT_R2_C23_RST = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] MAT_R3_C01_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] MAT_R3_C23_RST = 64'h0001_0000_0000_0000;

    // Control that travels down the pipeline beside each item.
    typedef struct packed {
        logic       valid;
        logic       w_zero;
        logic [2:0] sgn;     // sign of the quotient before the zero check
    } hpt_ctrl_t;

    // Picks one signed coefficient out of a register holding two of them.
    function automatic logic signed [COEF_W-1:0] coef_of(
        input logic [REG_W-1:0] reg_word,
        input logic             odd
    );
        logic signed [COEF_W-1:0] half;
        half = odd ? reg_word[REG_W-1:COEF_W] : reg_word[COEF_W-1:0];
        return half;
    endfunction

endpackage

// File: hdl/hpt_front.sv
// Front end of the transform: products, column sums and magnitudes.
// Three register stages; uses hpt_pkg for the control struct and coefficient pick.
`timescale 1ns / 1ps

module hpt_front #(
    parameter int CW = 32,
    parameter int F  = 16,
    parameter int SW = 83
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    in_valid,
    input  logic signed [CW-1:0]                                    px,
    input  logic signed [CW-1:0]                                    py,
    input  logic signed [CW-1:0]                                    pz,
    input  logic [hpt_pkg::NUM_REGS-1:0][hpt_pkg::REG_W-1:0]        mat,
    output hpt_pkg::hpt_ctrl_t                                      ctrl_out,
    output logic [2:0][SW+F-1:0]                                    num_out,
    output logic [SW-1:0]                                           den_out
);

    localparam int PW = CW + hpt_pkg::COEF_W;

    logic signed [hpt_pkg::COEF_W-1:0] coef_w [4][4];
    logic signed [CW-1:0]              pt     [3];

    logic signed [PW-1:0] prod_next [3][4];
    logic signed [PW-1:0] prod_reg  [3][4];
    logic                 va_reg;

    logic signed [SW-1:0] sum_next [4];
    logic signed [SW-1:0] sum_reg  [4];
    logic                 vb_reg;

    logic [3:0]           neg;
    logic [SW-1:0]        mag [4];
    hpt_pkg::hpt_ctrl_t   ctrl_next;
    hpt_pkg::hpt_ctrl_t   ctrl_reg;
    logic [2:0][SW+F-1:0] num_next;
    logic [2:0][SW+F-1:0] num_reg;
    logic [SW-1:0]        den_reg;

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    genvar r, c;
    generate
        for (r = 0; r < 4; r++) begin : g_row
            for (c = 0; c < 4; c++) begin : g_col
                assign coef_w[r][c] = hpt_pkg::coef_of(mat[r*2 + c/2], (c % 2) == 1);
            end
        end
        for (r = 0; r < 3; r++) begin : g_prow
            for (c = 0; c < 4; c++) begin : g_pcol
                assign prod_next[r][c] = pt[r] * coef_w[r][c];
            end
        end
    endgenerate

    // Column sums; the translation row enters scaled to the product's fraction.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sum_next[k] = SW'(prod_reg[0][k]) + SW'(prod_reg[1][k]) + SW'(prod_reg[2][k])
                        + (SW'(coef_w[3][k]) <<< F);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            neg[k] = sum_reg[k][SW-1];
            mag[k] = neg[k] ? SW'(-sum_reg[k]) : SW'(sum_reg[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            num_next[k] = {mag[k], {F{1'b0}}};
        end
        ctrl_next.valid  = vb_reg;
        ctrl_next.w_zero = (sum_reg[3] == '0);
        ctrl_next.sgn    = neg[2:0] ^ {3{neg[3]}};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        num_reg  <= num_next;
        den_reg  <= mag[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            ctrl_reg <= '0;
        end
        else
        begin
            va_reg   <= in_valid;
            vb_reg   <= va_reg;
            ctrl_reg <= ctrl_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;

endmodule

// File: hdl/hpt_div_stage.sv
// One restoring-division stage: settles quotient bit SHIFT for all three coordinates.
// Uses hpt_pkg for the control struct.
`timescale 1ns / 1ps

module hpt_div_stage #(
    parameter int CW    = 32,
    parameter int MW    = 83,
    parameter int RW    = 116,
    parameter int SHIFT = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hpt_pkg::hpt_ctrl_t    ctrl_in,
    input  logic [2:0][RW-1:0]    rem_in,
    input  logic [2:0][CW:0]      quo_in,
    input  logic [MW-1:0]         den_in,
    output hpt_pkg::hpt_ctrl_t    ctrl_out,
    output logic [2:0][RW-1:0]    rem_out,
    output logic [2:0][CW:0]      quo_out,
    output logic [MW-1:0]         den_out
);

    logic [RW-1:0]       dsh;
    logic [2:0][RW-1:0]  rem_next;
    logic [2:0][CW:0]    quo_next;
    hpt_pkg::hpt_ctrl_t  ctrl_reg;
    logic [2:0][RW-1:0]  rem_reg;
    logic [2:0][CW:0]    quo_reg;
    logic [MW-1:0]       den_reg;

    assign dsh = RW'(den_in) << SHIFT;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rem_next[k] = rem_in[k];
            quo_next[k] = quo_in[k];
            if (rem_in[k] >= dsh)
            begin
                rem_next[k]        = rem_in[k] - dsh;
                quo_next[k][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign den_out  = den_reg;

endmodule

// File: hdl/homogeneous_point_transform_unit.sv
// Throughput: one item per clock; busy stays low, so start may be high every cycle.
// Rate is set by a fully pipelined datapath: three front stages, one restoring
// division stage per quotient bit (COORD_WIDTH + 1 of them), one output stage.
// Reset (rst_n low, asynchronous) loads the identity matrix and drops every item in flight.
// The receiver cannot stall; each result shows on the outputs for one cycle with done high.
`timescale 1ns / 1ps

module homogeneous_point_transform_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   point_x,
    input  logic signed [COORD_WIDTH-1:0]   point_y,
    input  logic signed [COORD_WIDTH-1:0]   point_z,
    input  logic                            wr_en,
    input  logic [hpt_pkg::IDX_W-1:0]       wr_index,
    input  logic [hpt_pkg::REG_W-1:0]       wr_data,
    output logic                            done,
    output logic signed [COORD_WIDTH-1:0]   out_x,
    output logic signed [COORD_WIDTH-1:0]   out_y,
    output logic signed [COORD_WIDTH-1:0]   out_z,
    output logic                            w_zero,
    output logic                            overflow
);

    // Column sums need room for three full products, the translation term
    // and a sign; the numerator carries FRAC_BITS more, and the remainder
    // must also hold the divisor shifted by COORD_WIDTH for the saturation test.
    localparam int CW   = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int SW   = ((CW > F) ? CW : F) + hpt_pkg::COEF_W + 3;
    localparam int NW   = SW + F;
    localparam int RW   = ((NW > SW + CW + 1) ? NW : SW + CW + 1);
    localparam int NSTG = CW + 1;

    localparam logic [CW:0] POS_LIM = (CW+1)'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [CW:0] NEG_LIM = (CW+1)'(64'd1 << (CW - 1));

    logic [hpt_pkg::NUM_REGS-1:0][hpt_pkg::REG_W-1:0] mat_reg;

    hpt_pkg::hpt_ctrl_t   front_ctrl;
    logic [2:0][NW-1:0]   front_num;
    logic [SW-1:0]        front_den;

    hpt_pkg::hpt_ctrl_t   st_ctrl [NSTG+1];
    logic [2:0][RW-1:0]   st_rem  [NSTG+1];
    logic [2:0][CW:0]     st_quo  [NSTG+1];
    logic [SW-1:0]        st_den  [NSTG+1];

    logic [2:0][CW-1:0]   res_next;
    logic                 ovf_next;
    logic [2:0][CW-1:0]   res_reg;
    logic                 wz_reg;
    logic                 ovf_reg;
    logic                 done_reg;

    // The pipeline never holds items back.
    assign busy = 1'b0;

    // Matrix registers; the user must write them only while the pipeline is empty (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= hpt_pkg::MAT_R0_C01_RST;
            mat_reg[1] <= hpt_pkg::MAT_R0_C23_RST;
            mat_reg[2] <= hpt_pkg::MAT_R1_C01_RST;
            mat_reg[3] <= hpt_pkg::MAT_R1_C23_RST;
            mat_reg[4] <= hpt_pkg::MAT_R2_C01_RST;
            mat_reg[5] <= hpt_pkg::MAT_R2_C23_RST;
            mat_reg[6] <= hpt_pkg::MAT_R3_C01_RST;
            mat_reg[7] <= hpt_pkg::MAT_R3_C23_RST;
        end
        else if (wr_en)
        begin
            mat_reg[wr_index] <= wr_data;
        end
    end

    hpt_front #(
        .CW (CW),
        .F  (F),
        .SW (SW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .px       (point_x),
        .py       (point_y),
        .pz       (point_z),
        .mat      (mat_reg),
        .ctrl_out (front_ctrl),
        .num_out  (front_num),
        .den_out  (front_den)
    );

    // The division chain starts with the scaled magnitude as remainder.
    assign st_ctrl[0] = front_ctrl;
    assign st_den[0]  = front_den;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            st_rem[0][k] = RW'(front_num[k]);
            st_quo[0][k] = '0;
        end
    end

    // The first stage tests bit COORD_WIDTH: if it sets, the quotient is out
    // of range and the lower bits no longer matter.
    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_div
            hpt_div_stage #(
                .CW    (CW),
                .MW    (SW),
                .RW    (RW),
                .SHIFT (CW - s)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl_in  (st_ctrl[s]),
                .rem_in   (st_rem[s]),
                .quo_in   (st_quo[s]),
                .den_in   (st_den[s]),
                .ctrl_out (st_ctrl[s+1]),
                .rem_out  (st_rem[s+1]),
                .quo_out  (st_quo[s+1]),
                .den_out  (st_den[s+1])
            );
        end
    endgenerate

    // Sign, saturation and the zero-w case. A quotient that truncates to zero
    // keeps a positive sign, so its limit is the positive one.
    always_comb
    begin
        logic [CW:0] q;
        logic [CW:0] lim;
        logic        neg;
        ovf_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            q   = st_quo[NSTG][k];
            neg = st_ctrl[NSTG].sgn[k] && (q != '0);
            lim = neg ? NEG_LIM : POS_LIM;
            if (q > lim)
            begin
                q        = lim;
                ovf_next = 1'b1;
            end
            res_next[k] = neg ? CW'(-q) : CW'(q);
            if (st_ctrl[NSTG].w_zero)
            begin
                res_next[k] = '0;
            end
        end
        if (st_ctrl[NSTG].w_zero)
        begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        wz_reg  <= st_ctrl[NSTG].w_zero;
        ovf_reg <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= st_ctrl[NSTG].valid;
        end
    end

    assign done     = done_reg;
    assign out_x    = res_reg[0];
    assign out_y    = res_reg[1];
    assign out_z    = res_reg[2];
    assign w_zero   = wz_reg;
    assign overflow = ovf_reg;

endmodule
